@@ hdl/sflt_pkg.sv @@
// Shared types and codes for the spliced-frame transform.
// Beat payload structs, opcode and sweep-mode codes, controller/datapath command and status.
// No dependencies.
`default_nettype none

package sflt_pkg;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ELEM = 2'd1,
        OP_END  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SW_FILL = 2'd0,
        SW_STG  = 2'd1,
        SW_DUP  = 2'd2,
        SW_MAC  = 2'd3
    } mode_t;

    localparam logic REG_ROWS  = 1'b0;
    localparam logic REG_SHIFT = 1'b1;

    localparam logic [6:0] ROWS_RESET  = 7'd40;
    localparam logic [4:0] SHIFT_RESET = 5'd14;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [13:0]        coef_addr;
        logic signed [15:0] coef_value;
        logic signed [15:0] sample;
        logic               last_in_frame;
        logic               end_hint;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         row_index;
        logic               last;
        logic               drained;
    } result_t;

    typedef struct packed {
        logic  coef_we;
        logic  elem_we;
        logic  pos_clear;
        logic  advance;
        logic  sweep_go;
        mode_t sweep_mode;
        logic  row_clear;
        logic  load_out;
        logic  load_drain;
    } cmd_t;

    typedef struct packed {
        logic sweep_busy;
        logic res_valid;
        logic out_free;
        logic last_row;
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/sflt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module sflt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/sflt_ctrl.sv @@
// Controller state machine: input handshake, frame count, sweep and row sequencing.
// Depends on sflt_pkg.
`default_nettype none

module sflt_ctrl #(
    parameter int WIN = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire sflt_pkg::item_t item,
    input  wire sflt_pkg::sts_t  sts,
    output sflt_pkg::cmd_t       cmd
);

    localparam int NSLOT = 2 * WIN + 1;
    localparam int FW    = $clog2(NSLOT + 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_COPY     = 5'b00010,
        ST_ROW_GO   = 5'b00100,
        ST_ROW_WAIT = 5'b01000,
        ST_DRAIN    = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    logic [FW-1:0]  fh_reg, fh_next;
    logic           go_mac_reg, go_mac_next;
    logic           accept;
    logic [FW-1:0]  fh_inc;
    logic           emit_frame;
    logic           drop_frame;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);

    assign fh_inc     = (fh_reg == FW'(NSLOT)) ? fh_reg : fh_reg + 1'b1;
    assign emit_frame = (fh_inc > FW'(WIN));
    assign drop_frame = emit_frame && ((fh_inc == FW'(NSLOT)) || item.end_hint);

    always_comb
    begin
        state_next     = state_reg;
        fh_next        = fh_reg;
        go_mac_next    = go_mac_reg;
        cmd            = '0;
        cmd.sweep_mode = sflt_pkg::SW_MAC;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (sflt_pkg::op_t'(item.opcode))
                        sflt_pkg::OP_LOAD:
                        begin
                            cmd.coef_we = 1'b1;
                        end
                        sflt_pkg::OP_ELEM:
                        begin
                            cmd.elem_we = 1'b1;
                            if (item.last_in_frame)
                            begin
                                cmd.pos_clear = 1'b1;
                                cmd.sweep_go  = 1'b1;
                                if (fh_reg != '0)
                                begin
                                    cmd.advance    = 1'b1;
                                    cmd.sweep_mode = sflt_pkg::SW_STG;
                                end
                                else
                                begin
                                    cmd.sweep_mode = sflt_pkg::SW_FILL;
                                end
                                fh_next     = drop_frame ? fh_inc - 1'b1 : fh_inc;
                                go_mac_next = emit_frame;
                                state_next  = ST_COPY;
                            end
                        end
                        sflt_pkg::OP_END:
                        begin
                            cmd.pos_clear = 1'b1;
                            if (fh_reg <= FW'(WIN))
                            begin
                                fh_next    = '0;
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                cmd.advance    = 1'b1;
                                cmd.sweep_go   = 1'b1;
                                cmd.sweep_mode = sflt_pkg::SW_DUP;
                                fh_next        = fh_reg - 1'b1;
                                go_mac_next    = 1'b1;
                                state_next     = ST_COPY;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (!sts.sweep_busy)
                begin
                    if (go_mac_reg)
                    begin
                        cmd.row_clear = 1'b1;
                        state_next    = ST_ROW_GO;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROW_GO:
            begin
                cmd.sweep_go   = 1'b1;
                cmd.sweep_mode = sflt_pkg::SW_MAC;
                state_next     = ST_ROW_WAIT;
            end
            ST_ROW_WAIT:
            begin
                if (sts.res_valid && sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = sts.last_row ? ST_IDLE : ST_ROW_GO;
                end
            end
            ST_DRAIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_drain = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fh_reg     <= '0;
            go_mac_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fh_reg     <= fh_next;
            go_mac_reg <= go_mac_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sflt_dp.sv @@
// Datapath: staging, window and coefficient RAMs, sweep address engine, MAC pipeline,
// shift/saturate and the result register. Depends on sflt_pkg and sflt_ram.
`default_nettype none

module sflt_dp #(
    parameter int WIN        = 4,
    parameter int VEC        = 40,
    parameter int MAX_ROWS   = 64,
    parameter int COEF_DEPTH = 16384
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sflt_pkg::item_t   item,
    input  wire sflt_pkg::cmd_t    cmd,
    output sflt_pkg::sts_t         sts,
    input  wire logic [6:0]        rows_in_use,
    input  wire logic [4:0]        out_shift,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output sflt_pkg::result_t      result
);

    localparam int NSLOT = 2 * WIN + 1;
    localparam int TOTAL = NSLOT * VEC;
    localparam int WAW   = $clog2(TOTAL);
    localparam int EW    = VEC > 1 ? $clog2(VEC) : 1;
    localparam int PW    = $clog2(VEC + 1);
    localparam int CAW   = COEF_DEPTH > 1 ? $clog2(COEF_DEPTH) : 1;
    localparam int MW    = $clog2(MAX_ROWS * TOTAL + 1);
    localparam int CW0   = MW > CAW ? MW : CAW;
    localparam int CW    = (CW0 > 14 ? CW0 : 14) + 1;

    localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = 48'shFFFF_8000_0000;

    logic [PW-1:0]          pos_reg, pos_next;
    logic [WAW-1:0]         head_base_reg, head_base_next;
    logic [WAW-1:0]         newest_base_reg, newest_base_next;
    logic [WAW-1:0]         src_base_reg, src_base_next;
    logic                   active_reg, active_next;
    sflt_pkg::mode_t        mode_reg, mode_next;
    logic [WAW-1:0]         cnt_reg, cnt_next;
    logic [WAW-1:0]         last_idx_reg, last_idx_next;
    logic [WAW-1:0]         ra_reg, ra_next;
    logic [WAW-1:0]         wa_reg, wa_next;
    logic [EW-1:0]          e_reg, e_next;
    logic [CW-1:0]          coef_base_reg, coef_base_next;
    logic [5:0]             row_reg, row_next;

    logic                   s1_valid_reg, s1_valid_next;
    sflt_pkg::mode_t        s1_mode_reg, s1_mode_next;
    logic [WAW-1:0]         s1_wa_reg, s1_wa_next;
    logic                   s1_zero_reg, s1_zero_next;
    logic                   s1_last_reg, s1_last_next;
    logic                   p_valid_reg, p_valid_next;
    logic                   p_last_reg, p_last_next;
    logic signed [31:0]     p_reg, p_next;
    logic signed [47:0]     acc_reg, acc_next;
    logic                   fin_valid_reg, fin_valid_next;
    logic signed [47:0]     fin_reg, fin_next;
    logic                   sh_valid_reg, sh_valid_next;
    logic signed [47:0]     sh_reg, sh_next;
    logic                   res_valid_reg, res_valid_next;
    logic signed [31:0]     res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    sflt_pkg::result_t      out_reg, out_next;

    logic [CW-1:0]          load_addr;
    logic [CW-1:0]          caddr;
    logic                   coef_we;
    logic                   stg_we;
    logic                   win_we;
    logic [15:0]            win_wdata;
    logic signed [15:0]     win_rdata;
    logic signed [15:0]     stg_rdata;
    logic signed [15:0]     coef_rdata;
    logic signed [15:0]     coef_use;
    logic signed [47:0]     acc_sum;
    logic [WAW-1:0]         head_inc;
    logic [6:0]             rows_eff;
    logic                   last_row;
    logic                   out_free;

    assign load_addr = CW'(item.coef_addr);
    assign coef_we   = cmd.coef_we && (load_addr < CW'(COEF_DEPTH));
    assign stg_we    = cmd.elem_we && (pos_reg < PW'(VEC));
    assign caddr     = coef_base_reg + CW'(cnt_reg);

    sflt_ram #(.WIDTH(16), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (load_addr[CAW-1:0]),
        .wdata (item.coef_value),
        .raddr (caddr[CAW-1:0]),
        .rdata (coef_rdata)
    );

    sflt_ram #(.WIDTH(16), .DEPTH(VEC)) u_stg_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (pos_reg[EW-1:0]),
        .wdata (item.sample),
        .raddr (e_reg),
        .rdata (stg_rdata)
    );

    assign win_we    = s1_valid_reg && (s1_mode_reg != sflt_pkg::SW_MAC);
    assign win_wdata = (s1_mode_reg == sflt_pkg::SW_DUP) ? win_rdata : stg_rdata;

    sflt_ram #(.WIDTH(16), .DEPTH(TOTAL)) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (s1_wa_reg),
        .wdata (win_wdata),
        .raddr (ra_reg),
        .rdata (win_rdata)
    );

    assign head_inc = (head_base_reg == WAW'(TOTAL - VEC)) ? '0 : head_base_reg + WAW'(VEC);

    always_comb
    begin
        if (rows_in_use == 7'd0)
        begin
            rows_eff = 7'd1;
        end
        else if (rows_in_use > 7'(MAX_ROWS))
        begin
            rows_eff = 7'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_in_use;
        end
    end

    assign last_row = ({1'b0, row_reg} == rows_eff - 7'd1);
    assign out_free = !out_valid_reg || !result_stall;

    // Element position, window ring bases, row bookkeeping.
    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.pos_clear)
        begin
            pos_next = '0;
        end
        else if (stg_we)
        begin
            pos_next = pos_reg + 1'b1;
        end

        head_base_next   = head_base_reg;
        newest_base_next = newest_base_reg;
        src_base_next    = src_base_reg;
        if (cmd.advance)
        begin
            src_base_next    = newest_base_reg;
            newest_base_next = head_base_reg;
            head_base_next   = head_inc;
        end

        row_next       = row_reg;
        coef_base_next = coef_base_reg;
        if (cmd.row_clear)
        begin
            row_next       = '0;
            coef_base_next = '0;
        end
        else if (cmd.load_out)
        begin
            row_next       = row_reg + 1'b1;
            coef_base_next = coef_base_reg + CW'(TOTAL);
        end
    end

    // Sweep address engine.
    always_comb
    begin
        active_next   = active_reg;
        mode_next     = mode_reg;
        cnt_next      = cnt_reg;
        last_idx_next = last_idx_reg;
        ra_next       = ra_reg;
        wa_next       = wa_reg;
        e_next        = e_reg;
        if (cmd.sweep_go)
        begin
            active_next = 1'b1;
            mode_next   = cmd.sweep_mode;
            cnt_next    = '0;
            e_next      = '0;
            unique case (cmd.sweep_mode)
                sflt_pkg::SW_FILL:
                begin
                    last_idx_next = WAW'(TOTAL - 1);
                    wa_next       = '0;
                    ra_next       = '0;
                end
                sflt_pkg::SW_STG:
                begin
                    last_idx_next = WAW'(VEC - 1);
                    wa_next       = newest_base_next;
                    ra_next       = '0;
                end
                sflt_pkg::SW_DUP:
                begin
                    last_idx_next = WAW'(VEC - 1);
                    wa_next       = newest_base_next;
                    ra_next       = src_base_next;
                end
                sflt_pkg::SW_MAC:
                begin
                    last_idx_next = WAW'(TOTAL - 1);
                    wa_next       = '0;
                    ra_next       = head_base_reg;
                end
                default:
                begin
                    last_idx_next = WAW'(TOTAL - 1);
                end
            endcase
        end
        else if (active_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            ra_next  = (ra_reg == WAW'(TOTAL - 1)) ? '0 : ra_reg + 1'b1;
            wa_next  = (wa_reg == WAW'(TOTAL - 1)) ? '0 : wa_reg + 1'b1;
            e_next   = (e_reg == EW'(VEC - 1)) ? '0 : e_reg + 1'b1;
            if (cnt_reg == last_idx_reg)
            begin
                active_next = 1'b0;
            end
        end
    end

    // MAC pipeline, shift and saturate.
    assign coef_use = s1_zero_reg ? 16'sd0 : coef_rdata;
    assign acc_sum  = acc_reg + 48'(p_reg);

    always_comb
    begin
        s1_valid_next = active_reg;
        s1_mode_next  = mode_reg;
        s1_wa_next    = wa_reg;
        s1_zero_next  = (caddr >= CW'(COEF_DEPTH));
        s1_last_next  = (cnt_reg == last_idx_reg);

        p_valid_next = s1_valid_reg && (s1_mode_reg == sflt_pkg::SW_MAC);
        p_last_next  = s1_last_reg;
        p_next       = 32'(win_rdata) * 32'(coef_use);

        acc_next       = acc_reg;
        fin_valid_next = 1'b0;
        fin_next       = fin_reg;
        if (cmd.sweep_go)
        begin
            acc_next = '0;
        end
        else if (p_valid_reg)
        begin
            if (p_last_reg)
            begin
                acc_next       = '0;
                fin_valid_next = 1'b1;
                fin_next       = acc_sum;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end

        sh_valid_next = fin_valid_reg;
        sh_next       = fin_reg >>> out_shift;

        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (cmd.load_out)
        begin
            res_valid_next = 1'b0;
        end
        else if (sh_valid_reg)
        begin
            res_valid_next = 1'b1;
            if (sh_reg > SAT_MAX)
            begin
                res_next = SAT_MAX[31:0];
            end
            else if (sh_reg < SAT_MIN)
            begin
                res_next = SAT_MIN[31:0];
            end
            else
            begin
                res_next = sh_reg[31:0];
            end
        end
    end

    // Result register.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        if (cmd.load_out)
        begin
            out_valid_next    = 1'b1;
            out_next.value     = res_reg;
            out_next.row_index = row_reg;
            out_next.last      = last_row;
            out_next.drained   = 1'b0;
        end
        else if (cmd.load_drain)
        begin
            out_valid_next     = 1'b1;
            out_next.value     = '0;
            out_next.row_index = '0;
            out_next.last      = 1'b1;
            out_next.drained   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            head_base_reg   <= '0;
            newest_base_reg <= WAW'((NSLOT - 1) * VEC);
            src_base_reg    <= '0;
            active_reg      <= 1'b0;
            mode_reg        <= sflt_pkg::SW_MAC;
            cnt_reg         <= '0;
            last_idx_reg    <= '0;
            row_reg         <= '0;
            coef_base_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            p_valid_reg     <= 1'b0;
            fin_valid_reg   <= 1'b0;
            sh_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            acc_reg         <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            head_base_reg   <= head_base_next;
            newest_base_reg <= newest_base_next;
            src_base_reg    <= src_base_next;
            active_reg      <= active_next;
            mode_reg        <= mode_next;
            cnt_reg         <= cnt_next;
            last_idx_reg    <= last_idx_next;
            row_reg         <= row_next;
            coef_base_reg   <= coef_base_next;
            s1_valid_reg    <= s1_valid_next;
            p_valid_reg     <= p_valid_next;
            fin_valid_reg   <= fin_valid_next;
            sh_valid_reg    <= sh_valid_next;
            res_valid_reg   <= res_valid_next;
            out_valid_reg   <= out_valid_next;
            acc_reg         <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg      <= ra_next;
        wa_reg      <= wa_next;
        e_reg       <= e_next;
        s1_mode_reg <= s1_mode_next;
        s1_wa_reg   <= s1_wa_next;
        s1_zero_reg <= s1_zero_next;
        s1_last_reg <= s1_last_next;
        p_last_reg  <= p_last_next;
        p_reg       <= p_next;
        fin_reg     <= fin_next;
        sh_reg      <= sh_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign sts.sweep_busy = active_reg || s1_valid_reg;
    assign sts.res_valid  = res_valid_reg;
    assign sts.out_free   = out_free;
    assign sts.last_row   = last_row;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

@@ hdl/spliced_frame_lda_transform.sv @@
// Top level of the spliced-frame transform: APB register file, controller and datapath.
// Depends on sflt_pkg, sflt_ctrl, sflt_dp (and sflt_ram through sflt_dp).
//
//   channel  | beat signals                      | payload
//   item     | item_valid / item_stall           | sflt_pkg::item_t
//   result   | result_valid / result_stall       | sflt_pkg::result_t
//   config   | psel penable pwrite paddr pwdata  | rows_in_use @0x0, out_shift @0x4
//
// Coefficient loads and mid-frame elements are taken without leaving idle; an end step on a short window drains.
// Frame end: a frame into an empty window fills every slot (window fill), else it is copied into one slot (slot copy).
// Each result row sweeps the whole window through the single MAC unit and one window read port.
// Reset clears control state only; window contents are rebuilt by the first frame.
// A stalled result holds the next row in the pipeline; no input beat is taken while busy.
`default_nettype none

module spliced_frame_lda_transform #(
    parameter int WIN        = 4,
    parameter int VEC        = 40,
    parameter int MAX_ROWS   = 64,
    parameter int COEF_DEPTH = 16384
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire sflt_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output sflt_pkg::result_t      result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [6:0]     rows_reg, rows_next;
    logic [4:0]     shift_reg, shift_next;
    logic           cfg_write;
    sflt_pkg::cmd_t cmd;
    sflt_pkg::sts_t sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        rows_next  = rows_reg;
        shift_next = shift_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                sflt_pkg::REG_ROWS:  rows_next  = pwdata[6:0];
                sflt_pkg::REG_SHIFT: shift_next = pwdata[4:0];
                default:             rows_next  = rows_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            sflt_pkg::REG_ROWS:  prdata = {25'd0, rows_reg};
            sflt_pkg::REG_SHIFT: prdata = {27'd0, shift_reg};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= sflt_pkg::ROWS_RESET;
            shift_reg <= sflt_pkg::SHIFT_RESET;
        end
        else
        begin
            rows_reg  <= rows_next;
            shift_reg <= shift_next;
        end
    end

    sflt_ctrl #(.WIN(WIN)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .sts        (sts),
        .cmd        (cmd)
    );

    sflt_dp #(
        .WIN        (WIN),
        .VEC        (VEC),
        .MAX_ROWS   (MAX_ROWS),
        .COEF_DEPTH (COEF_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .rows_in_use  (rows_reg),
        .out_shift    (shift_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for spliced_frame_lda_transform: random frames, end steps and loads.
// Predicts every result row with a scoreboard class and checks it; depends on sflt_pkg.
`timescale 1ns / 100ps

module testbench;

    localparam int WIN        = 4;
    localparam int VEC        = 40;
    localparam int MAX_ROWS   = 64;
    localparam int COEF_DEPTH = 16384;
    localparam int NSLOT      = 2 * WIN + 1;
    localparam int SPAN       = NSLOT * VEC;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int SETTLE     = 400;
    localparam int LIMIT      = 1500000;

    class lda_scoreboard;
        int      window[SPAN];
        shortint coefs[COEF_DEPTH];
        int      staging[VEC];
        int      held;
        int      pos;
        int      rows_cfg;
        int      shift_cfg;
        int      errors;
        sflt_pkg::result_t rows_due[$];

        function void reset_state();
            foreach (window[j]) window[j] = 0;
            held = 0;
            pos = 0;
            rows_cfg = sflt_pkg::ROWS_RESET;
            shift_cfg = sflt_pkg::SHIFT_RESET;
            errors = 0;
        endfunction

        function void slide();
            for (int j = 0; j < SPAN - VEC; j++) window[j] = window[j + VEC];
        endfunction

        function void compute_rows();
            int rows;
            longint acc;
            longint v;
            int idx;
            sflt_pkg::result_t r;
            rows = rows_cfg == 0 ? 1 : (rows_cfg > MAX_ROWS ? MAX_ROWS : rows_cfg);
            for (int k = 0; k < rows; k++)
            begin
                acc = 0;
                for (int j = 0; j < SPAN; j++)
                begin
                    idx = k * SPAN + j;
                    if (idx < COEF_DEPTH) acc += longint'(window[j]) * longint'(coefs[idx]);
                end
                v = acc >>> shift_cfg;
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                if (v < -64'sd2147483648) v = -64'sd2147483648;
                r.value = v[31:0];
                r.row_index = k[5:0];
                r.last = (k == rows - 1);
                r.drained = 1'b0;
                rows_due.push_back(r);
            end
        endfunction

        function void note_item(sflt_pkg::item_t it);
            sflt_pkg::result_t r;
            case (it.opcode)
                sflt_pkg::OP_LOAD: coefs[it.coef_addr] = it.coef_value;
                sflt_pkg::OP_ELEM:
                begin
                    if (pos < VEC)
                    begin
                        staging[pos] = it.sample;
                        pos++;
                    end
                    if (it.last_in_frame)
                    begin
                        pos = 0;
                        if (held > 0) slide();
                        if (held == 0)
                        begin
                            for (int j = 0; j < SPAN; j++) window[j] = staging[j % VEC];
                        end
                        else
                        begin
                            for (int j = 0; j < VEC; j++) window[SPAN - VEC + j] = staging[j];
                        end
                        if (held < NSLOT) held++;
                        if (held > WIN)
                        begin
                            compute_rows();
                            if (held == NSLOT || it.end_hint) held--;
                        end
                    end
                end
                sflt_pkg::OP_END:
                begin
                    pos = 0;
                    if (held > 0) slide();
                    for (int j = 0; j < VEC; j++)
                        window[SPAN - VEC + j] = window[SPAN - 2 * VEC + j];
                    if (held <= WIN)
                    begin
                        held = 0;
                        r = '0;
                        r.last = 1'b1;
                        r.drained = 1'b1;
                        rows_due.push_back(r);
                    end
                    else
                    begin
                        compute_rows();
                        held--;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(sflt_pkg::result_t got);
            sflt_pkg::result_t want;
            if (rows_due.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = rows_due.pop_front();
            if (got.value !== want.value || got.row_index !== want.row_index ||
                got.last !== want.last || got.drained !== want.drained)
            begin
                $display("%0t: mismatch expected value %0d row %0d last %0b drained %0b",
                         $time, want.value, want.row_index, want.last, want.drained);
                $display("%0t:          actual   value %0d row %0d last %0b drained %0b",
                         $time, got.value, got.row_index, got.last, got.drained);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    sflt_pkg::item_t   item;
    logic              result_valid;
    logic              result_stall;
    sflt_pkg::result_t result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    lda_scoreboard sb;
    bit quiet;
    int stall_left;
    int cycles;
    int n_items;
    int n_results;

    spliced_frame_lda_transform u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("spliced_frame_lda_transform regression: fail");
            $finish;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
            n_results++;
        end
    end

    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            result_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else
            result_stall <= 1'b0;
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic send(sflt_pkg::item_t it);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!item_stall) break;
        end
        sb.note_item(it);
        n_items++;
    endtask

    task automatic send_op(logic [1:0] op, logic [13:0] addr, logic [15:0] coef,
                           logic [15:0] smp, logic lst, logic hint);
        sflt_pkg::item_t it;
        it.opcode = op;
        it.coef_addr = addr;
        it.coef_value = coef;
        it.sample = smp;
        it.last_in_frame = lst;
        it.end_hint = hint;
        send(it);
    endtask

    task automatic send_frame(int len, logic hint);
        for (int k = 0; k < len; k++)
            send_op(sflt_pkg::OP_ELEM, $urandom(), pick16(), pick16(), k == len - 1, hint);
    endtask

    task automatic drain_out();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.rows_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, int data);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {1'b0, idx, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == sflt_pkg::REG_ROWS) sb.rows_cfg = data & 7'h7f;
        else sb.shift_cfg = data & 5'h1f;
    endtask

    task automatic random_items(int count, int frame_max);
        int stop;
        stop = n_items + count;
        while (n_items < stop)
        begin
            case ($urandom_range(0, 19))
                0: send_op(sflt_pkg::OP_END, $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom());
                1: send_op(OP_SPARE, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                2: send_op(sflt_pkg::OP_LOAD, $urandom(), pick16(), $urandom(), $urandom(),
                           $urandom());
                3: send_frame($urandom_range(1, 3), $urandom()) ;
                4: send_op(sflt_pkg::OP_ELEM, $urandom(), $urandom(), pick16(), 1'b0,
                           $urandom());
                default: send_frame($urandom_range(1, frame_max), $urandom_range(0, 3) == 0);
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        quiet = 1'b0;
        stall_left = 0;
        cycles = 0;
        n_items = 0;
        n_results = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int a = 0; a < COEF_DEPTH; a++)
            send_op(sflt_pkg::OP_LOAD, a, pick16(), $urandom(), $urandom(), $urandom());

        send_op(sflt_pkg::OP_END, 14'h3fff, 16'h7fff, 16'h8000, 1'b1, 1'b1);
        send_op(OP_SPARE, 14'h0, 16'h8000, 16'h7fff, 1'b1, 1'b1);
        send_frame(VEC + 2, 1'b0);
        send_frame(2, 1'b0);
        send_op(sflt_pkg::OP_ELEM, 14'h0, 16'h0, 16'h7fff, 1'b0, 1'b0);
        send_op(sflt_pkg::OP_END, 14'h0, 16'h0, 16'h0, 1'b0, 1'b0);
        send_frame(1, 1'b0);
        send_frame(3, 1'b0);
        send_frame(1, 1'b0);
        send_frame(2, 1'b0);
        send_frame(4, 1'b1);
        send_op(sflt_pkg::OP_END, 14'h0, 16'h0, 16'h0, 1'b0, 1'b0);
        drain_out();

        write_reg(sflt_pkg::REG_ROWS, 1);
        write_reg(sflt_pkg::REG_SHIFT, 0);
        random_items(60, 6);
        drain_out();
        write_reg(sflt_pkg::REG_ROWS, 3);
        write_reg(sflt_pkg::REG_SHIFT, 31);
        random_items(50, VEC + 1);
        drain_out();
        write_reg(sflt_pkg::REG_ROWS, 64);
        write_reg(sflt_pkg::REG_SHIFT, 8);
        random_items(4, 2);
        drain_out();
        write_reg(sflt_pkg::REG_ROWS, 0);
        write_reg(sflt_pkg::REG_SHIFT, 20);
        random_items(50, 5);
        drain_out();
        write_reg(sflt_pkg::REG_ROWS, 127);
        write_reg(sflt_pkg::REG_SHIFT, 2);
        random_items(3, 2);
        drain_out();
        write_reg(sflt_pkg::REG_ROWS, 2);
        write_reg(sflt_pkg::REG_SHIFT, 14);
        quiet = 1'b1;
        random_items(40, 6);
        while (n_results < 60) random_items(10, 4);
        drain_out();

        if (sb.errors == 0)
            $display("spliced_frame_lda_transform regression: pass");
        else
            $display("spliced_frame_lda_transform regression: fail");
        $finish;
    end
endmodule
